/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SFX_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define SFX_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SFX_ASSERT_IMP(label, ante, cons)
`define SFX_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* rtl/sfx_pkg.sv */
package sfx_pkg;

    localparam int MAX_ELEMENTS_DEF = 64;
    localparam int CNT_W   = 7;
    localparam int LOGIT_W = 16;
    localparam int DATA_W  = 17;
    localparam int COL_W   = 23;
    localparam int IDX_W   = 2;
    localparam int Q_DEPTH = 2;

    localparam logic [IDX_W-1:0] CFG_CHANNEL = IDX_W'(0);
    localparam logic [IDX_W-1:0] CFG_INNER   = IDX_W'(1);

    localparam logic [CNT_W-1:0] CH_RESET  = CNT_W'(10);
    localparam logic [CNT_W-1:0] INN_RESET = CNT_W'(1);

    localparam logic [15:0] EXP_LIMIT = 16'd3072;

    typedef struct packed {
        logic [CNT_W-1:0] ch;
        logic [CNT_W-1:0] inn;
        logic [CNT_W-1:0] total;
        logic             ovf;
    } t_desc;

    typedef struct packed {
        logic              en;
        logic [CNT_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } t_st_wr;

    typedef logic [32:0] t_exp_tab [256];
    typedef logic [CNT_W-1:0] t_quot_tab [128];

    // Shift and subtract quotient, used only to build constant tables.
    function automatic longint unsigned f_udiv(longint unsigned num, longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Q32 value of exp(-r/256) from an alternating series of twenty-one terms.
    function automatic logic [32:0] f_neg_exp(int unsigned r);
        longint unsigned term;
        longint unsigned s;
        term = 64'd1 << 32;
        s = term;
        for (int n = 1; n <= 20; n++) begin
            term = f_udiv(term * longint'(r), longint'(256 * n));
            if (n % 2 == 1) begin
                s = s - term;
            end else begin
                s = s + term;
            end
        end
        return s[32:0];
    endfunction

    function automatic t_exp_tab f_exp_tab();
        t_exp_tab t;
        for (int r = 0; r < 256; r++) begin
            t[r] = f_neg_exp(r);
        end
        return t;
    endfunction

    function automatic t_quot_tab f_quot_tab(int unsigned max_el);
        t_quot_tab t;
        for (int n = 0; n < 128; n++) begin
            t[n] = (n == 0) ? CNT_W'(0) : CNT_W'(f_udiv(longint'(max_el), longint'(n)));
        end
        return t;
    endfunction

    localparam t_exp_tab    EXP_TAB = f_exp_tab();
    localparam logic [32:0] INV_E   = f_neg_exp(256);

endpackage

/* rtl/sfx_front.sv */
module sfx_front import sfx_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [LOGIT_W-1:0] i_logit,
    output logic               o_stall,
    input  logic               i_cfg_valid,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CNT_W-1:0]   i_cfg_data,
    output logic               o_cfg_ready,
    input  logic               i_hold,
    output t_st_wr             o_wr,
    output logic               o_push,
    output t_desc              o_desc
);

    localparam logic [CNT_W-1:0] MAX_V = CNT_W'(MAX_ELEMENTS);
    localparam t_quot_tab QUOT_TAB = f_quot_tab(MAX_ELEMENTS);

    logic [CNT_W-1:0] r_ch;
    logic [CNT_W-1:0] r_inn;
    logic [CNT_W-1:0] r_load;
    logic             r_ovf;

    logic [CNT_W-1:0]   ch_e;
    logic [CNT_W-1:0]   inn_e;
    logic [CNT_W-1:0]   inn_c;
    logic [CNT_W-1:0]   quot;
    logic [CNT_W-1:0]   ch_c;
    logic [2*CNT_W-1:0] prod;
    logic [CNT_W-1:0]   total;
    logic               clipped;
    logic               accept;
    logic               room;
    logic [CNT_W-1:0]   n_load;
    logic               done;

    always_comb begin
        ch_e    = (r_ch == '0) ? CNT_W'(1) : r_ch;
        inn_e   = (r_inn == '0) ? CNT_W'(1) : r_inn;
        inn_c   = (inn_e > MAX_V) ? MAX_V : inn_e;
        quot    = QUOT_TAB[inn_c];
        ch_c    = (ch_e > quot) ? quot : ch_e;
        prod    = ch_c * inn_c;
        total   = prod[CNT_W-1:0];
        clipped = (inn_e > MAX_V) || (ch_e > quot);
        accept  = i_valid && !o_stall;
        room    = r_load < MAX_V;
        n_load  = room ? r_load + CNT_W'(1) : r_load;
        done    = n_load >= total;
    end

    assign o_stall     = i_hold;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        o_wr.en   = accept && room;
        o_wr.addr = r_load;
        o_wr.data = {1'b0, i_logit};
        o_push    = accept && done;
        o_desc.ch    = ch_c;
        o_desc.inn   = inn_c;
        o_desc.total = total;
        o_desc.ovf   = r_ovf || clipped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch   <= CH_RESET;
            r_inn  <= INN_RESET;
            r_load <= '0;
            r_ovf  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_CHANNEL) begin
                    r_ch <= i_cfg_data;
                end else if (i_cfg_index == CFG_INNER) begin
                    r_inn <= i_cfg_data;
                end
            end
            if (accept) begin
                if (done) begin
                    r_load <= '0;
                    r_ovf  <= r_ovf || clipped;
                end else begin
                    r_load <= n_load;
                end
            end
        end
    end

endmodule

/* rtl/sfx_queue.sv */
`include "assert_macros.svh"
module sfx_queue import sfx_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_desc i_data,
    input  logic  i_pop,
    output t_desc o_data,
    output logic  o_not_empty
);

    localparam int QAW = $clog2(Q_DEPTH);

    t_desc          r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_count;

    assign o_data      = r_mem[r_rp];
    assign o_not_empty = r_count != '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QAW+1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QAW+1)'(1);
            end
        end
    end

    `SFX_ASSERT_IMP(a_no_overrun, i_push && !i_pop, r_count != (QAW+1)'(Q_DEPTH))
    `SFX_ASSERT_IMP(a_no_underrun, i_pop, r_count != '0)

endmodule

/* rtl/sfx_back.sv */
`include "assert_macros.svh"
module sfx_back import sfx_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_desc       i_desc,
    input  logic        i_desc_valid,
    output logic        o_pop,
    input  t_st_wr      i_fwr,
    output logic        o_busy,
    output logic [15:0] o_probability,
    output logic        o_last_result,
    output logic        o_overflow,
    output logic        o_valid,
    input  logic        i_stall
);

    localparam int AW = $clog2(MAX_ELEMENTS);

    typedef enum logic [3:0] {
        S_IDLE, S_A_RD, S_A_USE, S_E_RD, S_E_LOAD, S_E_MUL, S_E_RND, S_E_FIN,
        S_D_RD, S_D_INIT, S_D_STEP, S_D_EMIT
    } t_state;

    logic [DATA_W-1:0] r_store [MAX_ELEMENTS];
    logic [COL_W-1:0]  r_col [MAX_ELEMENTS];

    t_state            r_state;
    t_desc             r_desc;
    logic              r_sum_pass;
    logic [CNT_W-1:0]  r_j;
    logic [CNT_W-1:0]  r_i;
    logic [CNT_W-1:0]  r_c;
    logic [DATA_W-1:0] r_st_q;
    logic [COL_W-1:0]  r_col_q;
    logic [32:0]       r_v;
    logic [3:0]        r_q;
    logic [63:0]       r_prod;
    logic [COL_W-1:0]  r_rem;
    logic [COL_W-1:0]  r_den;
    logic [16:0]       r_quo;
    logic [16:0]       r_nb;
    logic [4:0]        r_dcnt;
    logic              r_out_valid;
    logic [15:0]       r_prob;
    logic              r_last;
    logic              r_ovf;

    logic              last_el;
    logic [CNT_W-1:0]  n_j;
    logic [CNT_W-1:0]  n_i;
    logic [CNT_W-1:0]  n_c;
    logic signed [15:0] x;
    logic signed [15:0] m;
    logic [16:0]       k;
    logic [15:0]       k16;
    logic [33:0]       e_sum;
    logic [16:0]       e_fin;
    logic [33:0]       rnd_sum;
    logic [32:0]       v_rnd;
    logic [COL_W:0]    dt;
    logic              dge;
    logic [COL_W:0]    dsub;
    logic              out_free;

    logic              st_we;
    logic [AW-1:0]     st_wa;
    logic [DATA_W-1:0] st_wd;
    logic              col_we;
    logic [COL_W-1:0]  col_wd;

    always_comb begin
        last_el  = r_j == r_desc.total - CNT_W'(1);
        n_j      = r_j + CNT_W'(1);
        if (r_i == r_desc.inn - CNT_W'(1)) begin
            n_i = '0;
            n_c = r_c + CNT_W'(1);
        end else begin
            n_i = r_i + CNT_W'(1);
            n_c = r_c;
        end
        x        = signed'(r_st_q[15:0]);
        m        = signed'(r_col_q[15:0]);
        k        = {m[15], m} - {x[15], x};
        k16      = k[15:0];
        e_sum    = {1'b0, r_v} + 34'd32768;
        e_fin    = e_sum[32:16];
        rnd_sum  = {1'b0, r_prod[63:31]} + 34'd1;
        v_rnd    = rnd_sum[33:1];
        dt       = {r_rem, r_nb[16]};
        dge      = dt >= {1'b0, r_den};
        dsub     = dt - {1'b0, r_den};
        out_free = !r_out_valid || !i_stall;
    end

    always_comb begin
        st_we  = 1'b0;
        st_wa  = r_j[AW-1:0];
        st_wd  = '0;
        col_we = 1'b0;
        col_wd = '0;
        unique case (r_state)
            S_IDLE: begin
                st_we = i_fwr.en;
                st_wa = i_fwr.addr[AW-1:0];
                st_wd = i_fwr.data;
            end
            S_A_USE: begin
                if (r_sum_pass) begin
                    col_we = 1'b1;
                    col_wd = ((r_c == '0) ? COL_W'(0) : r_col_q) + COL_W'(r_st_q);
                end else begin
                    col_we = (r_c == '0) || (x > m);
                    col_wd = COL_W'(r_st_q[15:0]);
                end
            end
            S_E_LOAD: begin
                st_we = k16 >= EXP_LIMIT;
            end
            S_E_FIN: begin
                st_we = 1'b1;
                st_wd = e_fin;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (st_we) begin
            r_store[st_wa] <= st_wd;
        end
        r_st_q <= r_store[r_j[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (col_we) begin
            r_col[r_i[AW-1:0]] <= col_wd;
        end
        r_col_q <= r_col[r_i[AW-1:0]];
    end

    assign o_pop         = (r_state == S_IDLE) && i_desc_valid;
    assign o_busy        = r_state != S_IDLE;
    assign o_valid       = r_out_valid;
    assign o_probability = r_prob;
    assign o_last_result = r_last;
    assign o_overflow    = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_desc_valid) begin
                        r_desc     <= i_desc;
                        r_sum_pass <= 1'b0;
                        r_j        <= '0;
                        r_i        <= '0;
                        r_c        <= '0;
                        r_state    <= S_A_RD;
                    end
                end
                S_A_RD: begin
                    r_state <= S_A_USE;
                end
                S_A_USE: begin
                    if (last_el) begin
                        r_j     <= '0;
                        r_i     <= '0;
                        r_c     <= '0;
                        r_state <= r_sum_pass ? S_D_RD : S_E_RD;
                    end else begin
                        r_j     <= n_j;
                        r_i     <= n_i;
                        r_c     <= n_c;
                        r_state <= S_A_RD;
                    end
                end
                S_E_RD: begin
                    r_state <= S_E_LOAD;
                end
                S_E_LOAD: begin
                    if (k16 >= EXP_LIMIT) begin
                        if (last_el) begin
                            r_sum_pass <= 1'b1;
                            r_j        <= '0;
                            r_i        <= '0;
                            r_c        <= '0;
                            r_state    <= S_A_RD;
                        end else begin
                            r_j     <= n_j;
                            r_i     <= n_i;
                            r_c     <= n_c;
                            r_state <= S_E_RD;
                        end
                    end else begin
                        r_v     <= EXP_TAB[k16[7:0]];
                        r_q     <= k16[11:8];
                        r_state <= (k16[11:8] == 4'd0) ? S_E_FIN : S_E_MUL;
                    end
                end
                S_E_MUL: begin
                    if (r_v[32]) begin
                        r_v     <= INV_E;
                        r_q     <= r_q - 4'd1;
                        r_state <= (r_q == 4'd1) ? S_E_FIN : S_E_MUL;
                    end else begin
                        r_prod  <= r_v[31:0] * INV_E[31:0];
                        r_state <= S_E_RND;
                    end
                end
                S_E_RND: begin
                    r_v     <= v_rnd;
                    r_q     <= r_q - 4'd1;
                    r_state <= (r_q == 4'd1) ? S_E_FIN : S_E_MUL;
                end
                S_E_FIN: begin
                    if (last_el) begin
                        r_sum_pass <= 1'b1;
                        r_j        <= '0;
                        r_i        <= '0;
                        r_c        <= '0;
                        r_state    <= S_A_RD;
                    end else begin
                        r_j     <= n_j;
                        r_i     <= n_i;
                        r_c     <= n_c;
                        r_state <= S_E_RD;
                    end
                end
                S_D_RD: begin
                    r_state <= S_D_INIT;
                end
                S_D_INIT: begin
                    r_rem   <= COL_W'(r_st_q[16:1]);
                    r_nb    <= {r_st_q[0], 16'd0};
                    r_den   <= r_col_q;
                    r_quo   <= '0;
                    r_dcnt  <= 5'd17;
                    r_state <= S_D_STEP;
                end
                S_D_STEP: begin
                    r_rem   <= dge ? dsub[COL_W-1:0] : dt[COL_W-1:0];
                    r_quo   <= {r_quo[15:0], dge};
                    r_nb    <= {r_nb[15:0], 1'b0};
                    r_dcnt  <= r_dcnt - 5'd1;
                    if (r_dcnt == 5'd1) begin
                        r_state <= S_D_EMIT;
                    end
                end
                S_D_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_prob      <= r_quo[16] ? 16'hFFFF : r_quo[15:0];
                        r_last      <= last_el;
                        r_ovf       <= r_desc.ovf;
                        if (last_el) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= n_j;
                            r_i     <= n_i;
                            r_c     <= n_c;
                            r_state <= S_D_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `SFX_ASSERT_IMP(a_exp_steps, (r_state == S_E_MUL) || (r_state == S_E_RND), (r_q != 4'd0) && (r_q <= 4'd11))
    `SFX_ASSERT_IMP(a_index_in_run, r_state != S_IDLE, r_j < r_desc.total)
    `SFX_ASSERT_NXT(a_run_ends, (r_state == S_D_EMIT) && out_free && last_el, (r_state == S_IDLE) && r_out_valid && r_last)

endmodule

/* rtl/softmax_over_channels.sv */
// Softmax over channels, fixed point.
// Logits (signed Q8.8) arrive on the input channel in channel-major order, one
// transfer per cycle while o_stall is low. channel_count and inner_count are set
// through the configuration port (index 0 and 1); the user must set them only
// while the block is idle, which the block itself does not enforce. A zero acts
// as one, and a size beyond MAX_ELEMENTS is clipped and sets the sticky overflow
// flag carried on every later result. When the last logit of a run is taken,
// o_stall rises and the block works from its element store: a max pass, an
// exponent pass (the single 32x32 multiplier steps through whole powers of e^-1
// for each element), a sum pass and a divide pass (one quotient bit per cycle).
// Results leave in load order through an output register; o_last_result marks
// the final one. A stall on the output only holds that register and the divide
// pass. The next run may start loading as soon as the last result is registered.
// Reset clears the sizes to their defaults (10 channels, 1 position), the load
// count and the overflow flag.
module softmax_over_channels import sfx_pkg::*; #(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [LOGIT_W-1:0] i_logit,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [15:0]        o_probability,
    output logic               o_last_result,
    output logic               o_overflow,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [CNT_W-1:0]   i_cfg_data
);

    t_st_wr fwr;
    t_desc  push_desc;
    t_desc  head_desc;
    logic   push;
    logic   pop;
    logic   not_empty;
    logic   busy;
    logic   hold;

    assign hold = not_empty || busy;

    sfx_front #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_logit     (i_logit),
        .o_stall     (o_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_hold      (hold),
        .o_wr        (fwr),
        .o_push      (push),
        .o_desc      (push_desc)
    );

    sfx_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data      (push_desc),
        .i_pop       (pop),
        .o_data      (head_desc),
        .o_not_empty (not_empty)
    );

    sfx_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_desc        (head_desc),
        .i_desc_valid  (not_empty),
        .o_pop         (pop),
        .i_fwr         (fwr),
        .o_busy        (busy),
        .o_probability (o_probability),
        .o_last_result (o_last_result),
        .o_overflow    (o_overflow),
        .o_valid       (o_valid),
        .i_stall       (i_stall)
    );

endmodule

/* test/tb_softmax_over_channels.sv */
`timescale 1ns / 100ps

typedef struct {
    logic [15:0] probability;
    logic        last_result;
    logic        overflow;
} prob_result_t;

class softmax_scoreboard;
    logic [6:0]         channel_reg;
    logic [6:0]         inner_reg;
    logic signed [15:0] logit_store[64];
    int                 stored;
    logic               overflow_flag;
    prob_result_t       pending_probs[$];
    int                 mismatches;
    int                 results_checked;
    int                 runs_done;
    int                 clipped_runs;

    function new();
        channel_reg = 7'd10;
        inner_reg = 7'd1;
        stored = 0;
        overflow_flag = 1'b0;
        mismatches = 0;
        results_checked = 0;
        runs_done = 0;
        clipped_runs = 0;
    endfunction

    function void set_reg(logic [1:0] index, logic [6:0] value);
        if (index == sfx_pkg::CFG_CHANNEL) begin
            channel_reg = value;
        end else if (index == sfx_pkg::CFG_INNER) begin
            inner_reg = value;
        end
    endfunction

    // Q32 value of exp(-r/256) by a twenty-one-term alternating series.
    function longint unsigned neg_exp_frac(int unsigned r);
        longint unsigned term;
        longint unsigned acc;
        term = 64'd1 << 32;
        acc = term;
        for (int n = 1; n <= 20; n++) begin
            term = (term * r) / (256 * n);
            acc = (n % 2 == 1) ? acc - term : acc + term;
        end
        return acc;
    endfunction

    function int unsigned exp_weight(int unsigned k);
        longint unsigned v;
        longint unsigned inv_e;
        if (k >= 3072) begin
            return 0;
        end
        v = neg_exp_frac(k % 256);
        inv_e = neg_exp_frac(256);
        for (int q = 0; q < k / 256; q++) begin
            v = (v * inv_e + 64'h8000_0000) >> 32;
        end
        return int'((v + 64'h8000) >> 16);
    endfunction

    function void note_logit(logic signed [15:0] x);
        int              ch;
        int              inn;
        int              total;
        bit              clipped;
        int              col_max[64];
        int unsigned     weight[64];
        int unsigned     col_sum[64];
        longint unsigned p;
        prob_result_t    r;
        ch = (channel_reg == 0) ? 1 : channel_reg;
        inn = (inner_reg == 0) ? 1 : inner_reg;
        clipped = 0;
        if (inn > 64) begin
            inn = 64;
            clipped = 1;
        end
        if (ch > 64 / inn) begin
            ch = 64 / inn;
            clipped = 1;
        end
        total = ch * inn;
        if (stored < 64) begin
            logit_store[stored] = x;
            stored++;
        end
        if (stored < total) begin
            return;
        end
        if (clipped) begin
            overflow_flag = 1'b1;
            clipped_runs++;
        end
        for (int i = 0; i < inn; i++) begin
            col_max[i] = logit_store[i];
            col_sum[i] = 0;
            for (int c = 1; c < ch; c++) begin
                if (logit_store[c * inn + i] > col_max[i]) begin
                    col_max[i] = logit_store[c * inn + i];
                end
            end
        end
        for (int j = 0; j < total; j++) begin
            weight[j] = exp_weight(col_max[j % inn] - int'(logit_store[j]));
            col_sum[j % inn] += weight[j];
        end
        for (int j = 0; j < total; j++) begin
            p = (longint'(weight[j]) << 16) / col_sum[j % inn];
            r.probability = (p > 65535) ? 16'hFFFF : p[15:0];
            r.last_result = (j + 1 == total);
            r.overflow = overflow_flag;
            pending_probs.push_back(r);
        end
        stored = 0;
        runs_done++;
    endfunction

    function void check_result(logic [15:0] prob, logic last, logic ovf);
        prob_result_t e;
        results_checked++;
        if (pending_probs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected result: probability %0d last %0d overflow %0d",
                         prob, last, ovf);
            end
            return;
        end
        e = pending_probs.pop_front();
        if (prob !== e.probability || last !== e.last_result || ovf !== e.overflow) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: expected probability %0d last %0d overflow %0d, got %0d %0d %0d",
                         e.probability, e.last_result, e.overflow, prob, last, ovf);
            end
        end
    endfunction
endclass

module tb_softmax_over_channels;
    import sfx_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic [LOGIT_W-1:0] i_logit;
    logic               o_stall;
    logic               o_valid;
    logic               i_stall;
    logic [15:0]        o_probability;
    logic               o_last_result;
    logic               o_overflow;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [IDX_W-1:0]   i_cfg_index;
    logic [CNT_W-1:0]   i_cfg_data;

    softmax_scoreboard board;
    bit                no_gaps;
    int                logits_sent;
    int                idle_cycles;

    softmax_over_channels dut (.*);

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)
            || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d results outstanding", board.pending_probs.size());
            $display("simulation failed");
            $finish;
        end
    end

    always begin
        int wait_cycles;
        wait_cycles = no_gaps ? 0 : $urandom_range(0, 15);
        repeat (wait_cycles) begin
            @(negedge i_clk);
            i_stall <= 1'b1;
        end
        @(negedge i_clk);
        i_stall <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (!(o_valid && i_rst_n));
        board.check_result(o_probability, o_last_result, o_overflow);
    end

    task automatic send_logit(logic signed [15:0] x);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_logit <= x;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        board.note_logit(x);
        logits_sent++;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] index, logic [CNT_W-1:0] value);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.pending_probs.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (60) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        board.set_reg(index, value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] random_logit(int anchor);
        int v;
        if ($urandom_range(0, 2) == 0) begin
            return 16'($urandom);
        end
        v = anchor - int'($urandom_range(0, 3400));
        if (v < -32768) begin
            v = -32768;
        end
        return v[15:0];
    endfunction

    task automatic random_run(int count);
        int anchor;
        anchor = $signed(16'($urandom));
        for (int n = 0; n < count; n++) begin
            send_logit(random_logit(anchor));
        end
    endtask

    initial begin
        int ch;
        int inn;
        int total;
        int pick;
        int phases;
        logic signed [15:0] edge_logits[10] = '{16'sh7FFF, 16'sh8000, 16'sh7FFF,
            16'sh73FF, 16'sh7400, 16'sh0000, 16'sh7F00, 16'sh7EFF, 16'sh00FF, 16'shFF00};
        board = new();
        no_gaps = 1'b0;
        logits_sent = 0;
        phases = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_logit = '0;
        i_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CHANNEL;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default sizes: ties at the top of the range, the exp cutoff and the full range.
        foreach (edge_logits[n]) begin
            send_logit(edge_logits[n]);
        end
        write_reg(CFG_CHANNEL, 7'd1);
        send_logit(16'sh8000);
        send_logit(16'sh1234);
        write_reg(CFG_CHANNEL, 7'd0);
        write_reg(CFG_INNER, 7'd0);
        send_logit(16'sh7FFF);
        write_reg(CFG_CHANNEL, 7'd2);
        write_reg(CFG_INNER, 7'd2);
        send_logit(16'sh0000);
        send_logit(16'sh0100);
        send_logit(16'sh0B00);
        send_logit(16'sh0000);

        while (logits_sent < 340) begin
            pick = $urandom_range(0, 15);
            case (pick)
                0: begin ch = 64; inn = 1; end
                1: begin ch = 1; inn = 64; end
                2: begin ch = 8; inn = 8; end
                3: begin ch = 100; inn = 1; end
                4: begin ch = 127; inn = 127; end
                5: begin ch = 7; inn = 20; end
                6: begin ch = 0; inn = $urandom_range(0, 3); end
                default: begin
                    ch = $urandom_range(1, 6);
                    inn = $urandom_range(1, 4);
                end
            endcase
            if (phases < 3) begin
                ch = 3 + phases;
                inn = 1 + phases;
            end
            write_reg(CFG_CHANNEL, ch[6:0]);
            write_reg(CFG_INNER, inn[6:0]);
            no_gaps = ($urandom_range(0, 4) == 0);
            ch = (ch == 0) ? 1 : ch;
            inn = (inn == 0) ? 1 : inn;
            inn = (inn > 64) ? 64 : inn;
            ch = (ch > 64 / inn) ? 64 / inn : ch;
            total = ch * inn;
            for (int run = 0; run < ((total > 16) ? 1 : $urandom_range(1, 4)); run++) begin
                random_run(total);
            end
            if ($urandom_range(0, 5) == 0) begin
                random_run($urandom_range(1, (total > 1) ? total - 1 : 1));
            end
            phases++;
        end
        no_gaps = 1'b0;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (board.pending_probs.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);
        $display("%0d logits over %0d size settings, %0d runs (%0d clipped), %0d results checked",
                 logits_sent, phases + 4, board.runs_done, board.clipped_runs,
                 board.results_checked);
        $display("%0d mismatches", board.mismatches);
        if (board.mismatches == 0 && board.pending_probs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

/* softmax_over_channels.f */
+incdir+rtl
rtl/sfx_pkg.sv
rtl/sfx_front.sv
rtl/sfx_queue.sv
rtl/sfx_back.sv
rtl/softmax_over_channels.sv
test/tb_softmax_over_channels.sv
